[rtl/core/mst_pkg.sv]
package mst_pkg;

   localparam int MAX_POINTS = 256;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;

   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int DIST_BITS  = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS  = DIST_BITS / 2 + FRAC_BITS + 1;
   localparam int TOTAL_BITS = 33;
   localparam int AVG_BITS   = 25;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
   localparam logic [AVG_BITS-1:0]   AVG_ONE   = AVG_BITS'(1) << FRAC_BITS;

endpackage

[rtl/core/mst_sqrt.sv]
// Restoring square root, one result bit per cycle: floor(sqrt(d * 4^FRAC_BITS))
module mst_sqrt import mst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIST_BITS-1:0]  radicand,
   output logic                  done,
   output logic [ROOT_BITS-1:0]  root
);
   localparam int RAD_BITS  = DIST_BITS + 2 * FRAC_BITS + 2;
   localparam int STEPS     = RAD_BITS / 2;
   localparam int STEP_BITS = $clog2(STEPS + 1);
   localparam int REM_BITS  = ROOT_BITS + 3;

   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [REM_BITS-1:0]  rem_sh, trial;

   // Shift in the next digit pair and try the next root bit
   always_comb begin
      rem_sh  = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
      trial   = REM_BITS'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = RAD_BITS'(radicand) << (2 * FRAC_BITS);
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_BITS'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

[rtl/core/mst_average_edge_length.sv]
// Minimum spanning tree edge-length averager.
// Request channel: a point (req_x_coord, req_y_coord, req_last_point) is
// taken at a clock edge where start is high and busy is low. Points fill
// the store in order; point 0 is the root. Points past MAX_POINTS are
// dropped and reported through rsp_overflow.
// After a point without req_last_point the block stays idle for the next
// point. The last point starts dense Prim over the N stored points: an
// init pass sets the best distances, then per admitted point a scan finds
// the minimum, a square root is taken, an update scan streams points
// through one shared subtract/square unit, and the write-back pipeline
// empties. A divide (one quotient bit per cycle) then gives the average.
// busy stays high until rsp_valid is raised.
// The result is on the rsp_ ports for exactly one cycle; the receiver
// cannot stall it.
// Reset clears counters and control; the point store needs no clearing,
// best distances and in-tree flags are set at the start of each run.
module mst_average_edge_length import mst_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic                         req_last_point,
   output logic                         rsp_valid,
   output logic [AVG_BITS-1:0]          rsp_average_length,
   output logic [TOTAL_BITS-1:0]        rsp_total_length,
   output logic                         rsp_used_default,
   output logic                         rsp_overflow
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_ROOT  = 4'd4;
   localparam logic [3:0] S_UPD   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam int DIV_BITS = TOTAL_BITS;
   localparam int DSTEP_BITS = $clog2(DIV_BITS + 1);

   logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
   // top bit marks a point already in the tree
   logic [DIST_BITS:0]    best_mem [MAX_POINTS];

   logic [3:0]            state_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  ovf_ff;
   logic [TOTAL_BITS-1:0] sum_ff;
   logic [CNT_BITS-1:0]   k_ff, p_ff;
   logic [IDX_BITS-1:0]   pick_ff;
   logic                  found_ff;
   logic [DIST_BITS-1:0]  min_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;

   // read pipeline: stage 1 memory data, stage 2 squares, stage 3 write
   logic                  r1_ff, r2_ff, r3_ff;
   logic [IDX_BITS-1:0]   a1_ff, a2_ff, a3_ff;
   logic signed [COORD_BITS-1:0] xr_ff, yr_ff;
   logic [DIST_BITS:0]    br_ff, b2_ff, b3_ff;
   logic [DIST_BITS-1:0]  sqx_ff, sqy_ff, d3_ff;

   logic                  sq_start;
   logic                  sq_done;
   logic [ROOT_BITS-1:0]  sq_root;

   logic [TOTAL_BITS-1:0] quo_ff;
   logic [CNT_BITS:0]     drem_ff;
   logic [DSTEP_BITS-1:0] dstep_ff;
   logic [CNT_BITS-1:0]   divisor;
   logic [CNT_BITS:0]     drem_sh;

   logic [AVG_BITS-1:0]   avg_ff;
   logic                  dflt_ff;
   logic [TOTAL_BITS-1:0] tot_ff;
   logic                  ovo_ff, vld_ff;

   logic signed [DIFF_BITS-1:0] dx, dy;
   logic [TOTAL_BITS:0]         sum_add;
   logic                        accept, stored;
   logic [IDX_BITS-1:0]         p_idx;
   logic                        upd_wr;

   assign accept  = start && (state_ff == S_IDLE);
   assign stored  = count_ff < CNT_BITS'(MAX_POINTS);
   assign p_idx   = p_ff[IDX_BITS-1:0];
   assign divisor = count_ff - 1'b1;
   assign drem_sh = {drem_ff[CNT_BITS-1:0], quo_ff[TOTAL_BITS-1]};
   assign sum_add = {1'b0, sum_ff} + (TOTAL_BITS+1)'(sq_root);
   assign sq_start = (state_ff == S_SQRT);
   assign dx = DIFF_BITS'(xr_ff) - DIFF_BITS'(px_ff);
   assign dy = DIFF_BITS'(yr_ff) - DIFF_BITS'(py_ff);
   // write back only during the update scan, only for points outside the tree
   assign upd_wr  = r3_ff && !b3_ff[DIST_BITS] && (d3_ff < b3_ff[DIST_BITS-1:0])
                    && ((state_ff == S_UPD) || (state_ff == S_DRAIN));

   mst_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (min_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   // Store points and read the store with one registered port
   always_ff @(posedge clock) begin
      if (accept && stored) begin
         x_mem[count_ff[IDX_BITS-1:0]] <= req_x_coord;
         y_mem[count_ff[IDX_BITS-1:0]] <= req_y_coord;
      end
      xr_ff <= x_mem[p_idx];
      yr_ff <= y_mem[p_idx];
   end

   // Best distance memory: init, admit to tree, pipelined write back
   always_ff @(posedge clock) begin
      if (state_ff == S_INIT)
         best_mem[p_idx] <= (p_ff == '0) ? '0 : {1'b0, {DIST_BITS{1'b1}}};
      else if (state_ff == S_SQRT)
         best_mem[pick_ff] <= {1'b1, min_ff};
      else if (upd_wr)
         best_mem[a3_ff] <= {1'b0, d3_ff};
      br_ff <= best_mem[p_idx];
   end

   // Square pipeline for the update scan
   always_ff @(posedge clock) begin
      a2_ff  <= a1_ff;
      b2_ff  <= br_ff;
      sqx_ff <= DIST_BITS'(dx * dx);
      sqy_ff <= DIST_BITS'(dy * dy);
      a3_ff  <= a2_ff;
      b3_ff  <= b2_ff;
      d3_ff  <= sqx_ff + sqy_ff;
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         vld_ff   <= 1'b0;
         r1_ff    <= 1'b0;
         r2_ff    <= 1'b0;
         r3_ff    <= 1'b0;
      end else begin
         vld_ff <= 1'b0;
         r2_ff  <= r1_ff;
         r3_ff  <= r2_ff;
         r1_ff  <= 1'b0;
         a1_ff  <= p_idx;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (stored)
                     count_ff <= count_ff + 1'b1;
                  else
                     ovf_ff <= 1'b1;
                  if (req_last_point) begin
                     state_ff <= S_INIT;
                     p_ff     <= '0;
                  end
               end
            end
            S_INIT: begin
               p_ff <= p_ff + 1'b1;
               if (p_ff + 1'b1 >= count_ff) begin
                  state_ff <= S_SCAN;
                  p_ff     <= '0;
                  k_ff     <= '0;
                  sum_ff   <= '0;
                  found_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               // r1 marks that br holds entry a1
               if (r1_ff && !br_ff[DIST_BITS]
                   && (!found_ff || br_ff[DIST_BITS-1:0] < min_ff)) begin
                  found_ff <= 1'b1;
                  min_ff   <= br_ff[DIST_BITS-1:0];
                  pick_ff  <= a1_ff;
               end
               if (p_ff < count_ff) begin
                  p_ff  <= p_ff + 1'b1;
                  r1_ff <= 1'b1;
               end
               if (!r1_ff && p_ff != '0) begin
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               p_ff <= {1'b0, pick_ff};
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (sq_done) begin
                  sum_ff <= sum_add[TOTAL_BITS] ? TOTAL_MAX : sum_add[TOTAL_BITS-1:0];
                  px_ff  <= xr_ff;
                  py_ff  <= yr_ff;
                  p_ff   <= '0;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (p_ff < count_ff) begin
                  p_ff  <= p_ff + 1'b1;
                  r1_ff <= 1'b1;
               end else begin
                  state_ff <= S_DRAIN;
                  p_ff     <= '0;
               end
            end
            S_DRAIN: begin
               // let the write-back pipeline empty
               if (!r1_ff && !r2_ff && !r3_ff) begin
                  if (k_ff + 1'b1 >= count_ff) begin
                     state_ff <= S_DIV;
                     quo_ff   <= sum_ff;
                     drem_ff  <= '0;
                     dstep_ff <= DSTEP_BITS'(DIV_BITS);
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     found_ff <= 1'b0;
                     p_ff     <= '0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_DIV: begin
               if (count_ff < CNT_BITS'(2)) begin
                  quo_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  if (drem_sh >= {1'b0, divisor}) begin
                     drem_ff <= drem_sh - {1'b0, divisor};
                     quo_ff  <= {quo_ff[TOTAL_BITS-2:0], 1'b1};
                  end else begin
                     drem_ff <= drem_sh;
                     quo_ff  <= {quo_ff[TOTAL_BITS-2:0], 1'b0};
                  end
                  dstep_ff <= dstep_ff - 1'b1;
                  if (dstep_ff == DSTEP_BITS'(1))
                     state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (quo_ff == '0) begin
                  avg_ff  <= AVG_ONE;
                  dflt_ff <= 1'b1;
               end else begin
                  avg_ff  <= (quo_ff > TOTAL_BITS'({AVG_BITS{1'b1}})) ? '1
                                                       : quo_ff[AVG_BITS-1:0];
                  dflt_ff <= 1'b0;
               end
               tot_ff   <= sum_ff;
               ovo_ff   <= ovf_ff;
               vld_ff   <= 1'b1;
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = vld_ff;
   assign rsp_average_length = avg_ff;
   assign rsp_total_length   = tot_ff;
   assign rsp_used_default   = dflt_ff;
   assign rsp_overflow       = ovo_ff;
endmodule
